// ===== sv/snfc_pkg.sv =====
package snfc_pkg;

   localparam int PAGE_BYTES   = 256;
   localparam int SECTOR_BYTES = 4096;
   localparam int BUF_BYTES    = 256;
   localparam int BUF_AW       = $clog2(BUF_BYTES);
   localparam int PAGE_AW      = $clog2(PAGE_BYTES);
   localparam int SECTOR_AW    = $clog2(SECTOR_BYTES);

   localparam int ADDR_W  = 24;
   localparam int LEN_W   = 16;
   localparam int POS_W   = 17;
   localparam int LIMIT_W = 16;

   localparam int FQ_DEPTH = 4;
   localparam int FQ_AW    = $clog2(FQ_DEPTH);
   localparam int OQ_DEPTH = 8;
   localparam int OQ_AW    = $clog2(OQ_DEPTH);
   localparam int OQ_CW    = OQ_AW + 1;

   // request opcodes
   localparam logic [2:0] OPC_LOAD  = 3'd0;
   localparam logic [2:0] OPC_ID    = 3'd1;
   localparam logic [2:0] OPC_READ  = 3'd2;
   localparam logic [2:0] OPC_ERASE = 3'd3;
   localparam logic [2:0] OPC_PROG  = 3'd4;
   localparam logic [2:0] OPC_SPI   = 3'd5;

   // response kinds
   localparam logic [1:0] KIND_TX   = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   // completion status
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_TIMEOUT = 3'd1;
   localparam logic [2:0] ST_SPI_ERR = 3'd2;
   localparam logic [2:0] ST_ALIGN   = 3'd3;
   localparam logic [2:0] ST_ARG     = 3'd4;

   localparam logic [1:0] SPI_OK      = 2'd0;
   localparam logic [1:0] SPI_TIMEOUT = 2'd1;

   // flash command bytes
   localparam logic [7:0] FL_READ_ID   = 8'h9F;
   localparam logic [7:0] FL_FAST_READ = 8'h0B;
   localparam logic [7:0] FL_WREN      = 8'h06;
   localparam logic [7:0] FL_SE        = 8'h20;
   localparam logic [7:0] FL_PP        = 8'h02;
   localparam logic [7:0] FL_RDSR1     = 8'h05;
   localparam logic [7:0] FL_DUMMY     = 8'h00;
   localparam logic [7:0] FL_FILL      = 8'hFF;

   localparam logic       CSR_ERASE_LIMIT = 1'b0;
   localparam logic       CSR_PROG_LIMIT  = 1'b1;
   localparam logic [LIMIT_W-1:0] ERASE_LIMIT_RST = 16'd1000;
   localparam logic [LIMIT_W-1:0] PROG_LIMIT_RST  = 16'd20;

   typedef enum logic [2:0] {
      IK_LOAD  = 3'd0,
      IK_ID    = 3'd1,
      IK_READ  = 3'd2,
      IK_ERASE = 3'd3,
      IK_PROG  = 3'd4,
      IK_SPI   = 3'd5
   } item_kind_type;

   typedef struct packed {
      item_kind_type     kind;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
      logic [7:0]        data_byte;
      logic [1:0]        spi_status;
      logic              arg_bad;
   } item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] byte_value;
      logic       frame_end;
      logic [2:0] status;
      logic       last;
   } result_type;

   typedef enum logic [8:0] {
      PH_IDLE       = 9'b000000001,
      PH_ID         = 9'b000000010,
      PH_READ       = 9'b000000100,
      PH_WE_ERASE   = 9'b000001000,
      PH_ERASE      = 9'b000010000,
      PH_WE_PROG    = 9'b000100000,
      PH_PROG       = 9'b001000000,
      PH_POLL_ERASE = 9'b010000000,
      PH_POLL_PROG  = 9'b100000000
   } phase_type;

endpackage

// ===== sv/snfc_front.sv =====
module snfc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [2:0]                   opcode,
   input  logic [snfc_pkg::ADDR_W-1:0]  address,
   input  logic [snfc_pkg::LEN_W-1:0]   length,
   input  logic [7:0]                   data_byte,
   input  logic [1:0]                   spi_status,
   output logic                         q_valid,
   output snfc_pkg::item_type           q_item,
   input  logic                         q_pop
);

   snfc_pkg::item_type           fifo_ff [snfc_pkg::FQ_DEPTH];
   snfc_pkg::item_type           item;
   logic                         keep;
   logic                         wr;
   logic [snfc_pkg::FQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [snfc_pkg::FQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [snfc_pkg::FQ_AW:0]     count_ff, count_in;

   // classify the request; unknown opcodes are dropped here
   always_comb begin
      keep = 1'b1;
      item.kind = snfc_pkg::IK_LOAD;
      item.address = address;
      item.length = length;
      item.data_byte = data_byte;
      item.spi_status = spi_status;
      item.arg_bad = 1'b0;
      case (opcode)
         snfc_pkg::OPC_LOAD: item.kind = snfc_pkg::IK_LOAD;
         snfc_pkg::OPC_ID: item.kind = snfc_pkg::IK_ID;
         snfc_pkg::OPC_READ: begin
            item.kind = snfc_pkg::IK_READ;
            item.arg_bad = (length == '0);
         end
         snfc_pkg::OPC_ERASE: begin
            item.kind = snfc_pkg::IK_ERASE;
            item.address = {address[snfc_pkg::ADDR_W-1:snfc_pkg::SECTOR_AW],
                            {snfc_pkg::SECTOR_AW{1'b0}}};
         end
         snfc_pkg::OPC_PROG: begin
            item.kind = snfc_pkg::IK_PROG;
            item.arg_bad = (address[snfc_pkg::PAGE_AW-1:0] != '0) || (length == '0) ||
                           ({1'b0, length} > (snfc_pkg::LEN_W+1)'(snfc_pkg::PAGE_BYTES));
         end
         snfc_pkg::OPC_SPI: item.kind = snfc_pkg::IK_SPI;
         default: keep = 1'b0;
      endcase
   end

   assign full    = (count_ff == (snfc_pkg::FQ_AW+1)'(snfc_pkg::FQ_DEPTH));
   assign wr      = push && !full && keep;
   assign q_valid = (count_ff != '0);
   assign q_item  = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + (snfc_pkg::FQ_AW)'(wr);
      rd_ptr_in = rd_ptr_ff + (snfc_pkg::FQ_AW)'(q_pop && q_valid);
      count_in  = count_ff + (snfc_pkg::FQ_AW+1)'(wr) - (snfc_pkg::FQ_AW+1)'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         fifo_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ===== sv/snfc_back.sv =====
module snfc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [snfc_pkg::LIMIT_W-1:0]  csr_wdata,
   input  logic                          in_valid,
   input  snfc_pkg::item_type            in_item,
   output logic                          in_pop,
   input  logic [snfc_pkg::OQ_CW-1:0]    oq_count,
   output logic [1:0]                    wr_n,
   output snfc_pkg::result_type          wr_r0,
   output snfc_pkg::result_type          wr_r1
);

   snfc_pkg::phase_type             phase_ff, phase_in;
   logic [snfc_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [snfc_pkg::LEN_W-1:0]      len_ff, len_in;
   logic [snfc_pkg::ADDR_W-1:0]     addr_ff, addr_in;
   logic [snfc_pkg::LIMIT_W-1:0]    polls_ff, polls_in, polls_inc;
   logic [snfc_pkg::LIMIT_W-1:0]    erase_limit_ff, prog_limit_ff, cur_limit;

   logic [7:0]                      page_mem [snfc_pkg::BUF_BYTES];
   logic [7:0]                      mem_q_ff;
   logic [snfc_pkg::BUF_AW-1:0]     mem_idx;
   logic                            mem_we;

   logic                            s2_valid_ff;
   logic [1:0]                      s2_n_ff;
   snfc_pkg::result_type            s2_r0_ff, s2_r1_ff;
   logic                            s2_use_mem_ff;

   logic                            fire, idle, space_ok;
   logic [snfc_pkg::OQ_CW+1:0]      need;
   logic                            emit_data, do_send, do_finish, use_mem;
   logic [2:0]                      fin_status;
   logic [snfc_pkg::POS_W-1:0]      send_p, pos_next, flen_cur, flen_new;
   logic [7:0]                      tx;
   snfc_pkg::result_type            fin_r, data_r, r0, r1;
   logic [1:0]                      n;

   function automatic logic [snfc_pkg::POS_W-1:0] frame_len(
      input snfc_pkg::phase_type ph, input logic [snfc_pkg::LEN_W-1:0] len);
      logic [snfc_pkg::POS_W-1:0] r;
      case (ph)
         snfc_pkg::PH_ID:         r = 17'd4;
         snfc_pkg::PH_READ:       r = 17'd5 + {1'b0, len};
         snfc_pkg::PH_ERASE:      r = 17'd4;
         snfc_pkg::PH_PROG:       r = 17'd4 + {1'b0, len};
         snfc_pkg::PH_POLL_ERASE: r = 17'd2;
         snfc_pkg::PH_POLL_PROG:  r = 17'd2;
         default:                 r = 17'd1;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] addr_byte(
      input logic [snfc_pkg::ADDR_W-1:0] a, input logic [snfc_pkg::POS_W-1:0] p);
      logic [7:0] r;
      case (p[1:0])
         2'd1:    r = a[23:16];
         2'd2:    r = a[15:8];
         default: r = a[7:0];
      endcase
      return r;
   endfunction

   assign idle      = (phase_ff == snfc_pkg::PH_IDLE);
   assign need      = (snfc_pkg::OQ_CW+2)'(oq_count) + (snfc_pkg::OQ_CW+2)'(s2_valid_ff ? s2_n_ff : 2'd0)
                      + (snfc_pkg::OQ_CW+2)'(2);
   assign space_ok  = (need <= (snfc_pkg::OQ_CW+2)'(snfc_pkg::OQ_DEPTH));
   assign fire      = in_valid && space_ok;
   assign in_pop    = fire;
   assign polls_inc = polls_ff + 1'b1;
   assign pos_next  = pos_ff + 1'b1;
   assign flen_cur  = frame_len(phase_ff, len_ff);
   assign cur_limit = (phase_ff == snfc_pkg::PH_POLL_ERASE) ? erase_limit_ff : prog_limit_ff;

   // sequencer decision for one transaction
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      len_in     = len_ff;
      addr_in    = addr_ff;
      polls_in   = polls_ff;
      emit_data  = 1'b0;
      do_send    = 1'b0;
      do_finish  = 1'b0;
      fin_status = snfc_pkg::ST_OK;
      send_p     = '0;
      mem_we     = 1'b0;
      if (fire) begin
         case (in_item.kind)
            snfc_pkg::IK_LOAD: mem_we = 1'b1;
            snfc_pkg::IK_ID: begin
               if (idle) begin
                  phase_in = snfc_pkg::PH_ID;
                  len_in   = '0;
                  do_send  = 1'b1;
               end
            end
            snfc_pkg::IK_READ: begin
               if (idle) begin
                  if (in_item.arg_bad) begin
                     do_finish  = 1'b1;
                     fin_status = snfc_pkg::ST_ARG;
                  end else begin
                     phase_in = snfc_pkg::PH_READ;
                     addr_in  = in_item.address;
                     len_in   = in_item.length;
                     do_send  = 1'b1;
                  end
               end
            end
            snfc_pkg::IK_ERASE: begin
               if (idle) begin
                  phase_in = snfc_pkg::PH_WE_ERASE;
                  addr_in  = in_item.address;
                  do_send  = 1'b1;
               end
            end
            snfc_pkg::IK_PROG: begin
               if (idle) begin
                  if (in_item.arg_bad) begin
                     do_finish  = 1'b1;
                     fin_status = snfc_pkg::ST_ALIGN;
                  end else begin
                     phase_in = snfc_pkg::PH_WE_PROG;
                     addr_in  = in_item.address;
                     len_in   = in_item.length;
                     do_send  = 1'b1;
                  end
               end
            end
            snfc_pkg::IK_SPI: begin
               if (!idle) begin
                  if (in_item.spi_status != snfc_pkg::SPI_OK) begin
                     do_finish  = 1'b1;
                     fin_status = (in_item.spi_status == snfc_pkg::SPI_TIMEOUT) ?
                                  snfc_pkg::ST_TIMEOUT : snfc_pkg::ST_SPI_ERR;
                  end else begin
                     emit_data = ((phase_ff == snfc_pkg::PH_ID) && (pos_ff >= 17'd1)) ||
                                 ((phase_ff == snfc_pkg::PH_READ) && (pos_ff >= 17'd5));
                     if (((phase_ff == snfc_pkg::PH_POLL_ERASE) ||
                          (phase_ff == snfc_pkg::PH_POLL_PROG)) && (pos_ff == 17'd1)) begin
                        // status byte of a poll frame: bit 0 is busy
                        if (!in_item.data_byte[0]) begin
                           do_finish = 1'b1;
                        end else begin
                           polls_in = polls_inc;
                           if (polls_inc >= cur_limit) begin
                              do_finish  = 1'b1;
                              fin_status = snfc_pkg::ST_TIMEOUT;
                           end else begin
                              do_send = 1'b1;
                           end
                        end
                     end else if (pos_next < flen_cur) begin
                        do_send = 1'b1;
                        send_p  = pos_next;
                     end else begin
                        case (phase_ff)
                           snfc_pkg::PH_WE_ERASE: begin
                              phase_in = snfc_pkg::PH_ERASE;
                              do_send  = 1'b1;
                           end
                           snfc_pkg::PH_WE_PROG: begin
                              phase_in = snfc_pkg::PH_PROG;
                              do_send  = 1'b1;
                           end
                           snfc_pkg::PH_ERASE: begin
                              if (erase_limit_ff == '0) begin
                                 do_finish  = 1'b1;
                                 fin_status = snfc_pkg::ST_TIMEOUT;
                              end else begin
                                 phase_in = snfc_pkg::PH_POLL_ERASE;
                                 polls_in = '0;
                                 do_send  = 1'b1;
                              end
                           end
                           snfc_pkg::PH_PROG: begin
                              if (prog_limit_ff == '0) begin
                                 do_finish  = 1'b1;
                                 fin_status = snfc_pkg::ST_TIMEOUT;
                              end else begin
                                 phase_in = snfc_pkg::PH_POLL_PROG;
                                 polls_in = '0;
                                 do_send  = 1'b1;
                              end
                           end
                           default: do_finish = 1'b1;
                        endcase
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      if (do_finish) begin
         phase_in = snfc_pkg::PH_IDLE;
         pos_in   = '0;
      end
      if (do_send) begin
         pos_in = send_p;
      end
   end

   // transmit byte for the position being sent
   always_comb begin
      use_mem = 1'b0;
      mem_idx = addr_in[snfc_pkg::BUF_AW-1:0] + send_p[snfc_pkg::BUF_AW-1:0]
                - (snfc_pkg::BUF_AW)'(4);
      flen_new = frame_len(phase_in, len_in);
      case (phase_in)
         snfc_pkg::PH_ID: tx = (send_p == '0) ? snfc_pkg::FL_READ_ID : snfc_pkg::FL_DUMMY;
         snfc_pkg::PH_READ: begin
            if (send_p == '0)            tx = snfc_pkg::FL_FAST_READ;
            else if (send_p <= 17'd3)    tx = addr_byte(addr_in, send_p);
            else if (send_p == 17'd4)    tx = snfc_pkg::FL_DUMMY;
            else                         tx = snfc_pkg::FL_FILL;
         end
         snfc_pkg::PH_WE_ERASE: tx = snfc_pkg::FL_WREN;
         snfc_pkg::PH_WE_PROG:  tx = snfc_pkg::FL_WREN;
         snfc_pkg::PH_ERASE: tx = (send_p == '0) ? snfc_pkg::FL_SE : addr_byte(addr_in, send_p);
         snfc_pkg::PH_PROG: begin
            if (send_p == '0)            tx = snfc_pkg::FL_PP;
            else if (send_p <= 17'd3)    tx = addr_byte(addr_in, send_p);
            else begin
               tx      = '0;
               use_mem = do_send;
            end
         end
         snfc_pkg::PH_POLL_ERASE: tx = (send_p == '0) ? snfc_pkg::FL_RDSR1 : snfc_pkg::FL_DUMMY;
         snfc_pkg::PH_POLL_PROG:  tx = (send_p == '0) ? snfc_pkg::FL_RDSR1 : snfc_pkg::FL_DUMMY;
         default: tx = '0;
      endcase
   end

   always_comb begin
      data_r.kind       = snfc_pkg::KIND_DATA;
      data_r.byte_value = in_item.data_byte;
      data_r.frame_end  = 1'b0;
      data_r.status     = snfc_pkg::ST_OK;
      data_r.last       = !(do_send || do_finish);
      if (do_finish) begin
         fin_r.kind       = snfc_pkg::KIND_DONE;
         fin_r.byte_value = '0;
         fin_r.frame_end  = 1'b1;
         fin_r.status     = fin_status;
      end else begin
         fin_r.kind       = snfc_pkg::KIND_TX;
         fin_r.byte_value = tx;
         fin_r.frame_end  = (send_p + 1'b1 == flen_new);
         fin_r.status     = snfc_pkg::ST_OK;
      end
      fin_r.last = 1'b1;
      if (emit_data) begin
         r0 = data_r;
         r1 = fin_r;
         n  = 2'd1 + 2'(do_send || do_finish);
      end else begin
         r0 = fin_r;
         r1 = fin_r;
         n  = 2'(do_send || do_finish);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= snfc_pkg::PH_IDLE;
         pos_ff         <= '0;
         len_ff         <= '0;
         addr_ff        <= '0;
         polls_ff       <= '0;
         erase_limit_ff <= snfc_pkg::ERASE_LIMIT_RST;
         prog_limit_ff  <= snfc_pkg::PROG_LIMIT_RST;
         s2_valid_ff    <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         len_ff      <= len_in;
         addr_ff     <= addr_in;
         polls_ff    <= polls_in;
         s2_valid_ff <= fire && (n != 2'd0);
         if (csr_we && (csr_index == snfc_pkg::CSR_ERASE_LIMIT)) begin
            erase_limit_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == snfc_pkg::CSR_PROG_LIMIT)) begin
            prog_limit_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      s2_n_ff       <= n;
      s2_r0_ff      <= r0;
      s2_r1_ff      <= r1;
      s2_use_mem_ff <= use_mem && fire;
   end

   // page buffer, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         page_mem[in_item.address[snfc_pkg::BUF_AW-1:0]] <= in_item.data_byte;
      end
      mem_q_ff <= page_mem[mem_idx];
   end

   always_comb begin
      wr_n  = s2_valid_ff ? s2_n_ff : 2'd0;
      wr_r0 = s2_r0_ff;
      wr_r1 = s2_r1_ff;
      if (s2_use_mem_ff) begin
         wr_r0.byte_value = mem_q_ff;
      end
   end

   a_s2_nonempty: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_n_ff != 2'd0))
      else $error("stage 2 holds a transaction with no results");

   a_mem_single_tx: assert property (@(posedge clock) disable iff (reset)
      s2_use_mem_ff |-> (s2_valid_ff && (s2_n_ff == 2'd1) && (s2_r0_ff.kind == snfc_pkg::KIND_TX)))
      else $error("page byte substituted into a result that is not a lone transmit");

   a_prog_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == snfc_pkg::PH_PROG) |->
         ((len_ff != '0) && ({1'b0, len_ff} <= (snfc_pkg::LEN_W+1)'(snfc_pkg::PAGE_BYTES))))
      else $error("program length outside page");

endmodule

// ===== sv/snfc_outq.sv =====
module snfc_outq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [1:0]                  wr_n,
   input  snfc_pkg::result_type        wr_r0,
   input  snfc_pkg::result_type        wr_r1,
   output logic [snfc_pkg::OQ_CW-1:0]  count,
   output logic                        empty,
   input  logic                        pop,
   output snfc_pkg::result_type        head
);

   snfc_pkg::result_type           fifo_ff [snfc_pkg::OQ_DEPTH];
   logic [snfc_pkg::OQ_AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [snfc_pkg::OQ_AW-1:0]     wr_ptr1;
   logic [snfc_pkg::OQ_CW-1:0]     count_ff, count_in;
   logic                           rd;

   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign head    = fifo_ff[rd_ptr_ff];
   assign rd      = pop && !empty;
   assign wr_ptr1 = wr_ptr_ff + 1'b1;
   assign count_in = count_ff + (snfc_pkg::OQ_CW)'(wr_n) - (snfc_pkg::OQ_CW)'(rd);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + (snfc_pkg::OQ_AW)'(wr_n);
         rd_ptr_ff <= rd_ptr_ff + (snfc_pkg::OQ_AW)'(rd);
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= wr_r0;
      end
      if (wr_n == 2'd2) begin
         fifo_ff[wr_ptr1] <= wr_r1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (snfc_pkg::OQ_CW)'(snfc_pkg::OQ_DEPTH))
      else $error("result queue overflow");

endmodule

// ===== sv/spi_nor_flash_command_sequencer_top.sv =====
// path: a request waits in the request queue, its results are registered in the result stage
//   (the page buffer read is registered alongside) and then written to the response queue
// throughput: one transaction per cycle, as long as the response queue has room for the
//   staged results plus two more; otherwise the request queue fills and full goes high
// reset: synchronous, active high; clears both queues, the command phase, counters and
//   restores the poll limits to 1000 (erase) and 20 (program); the page buffer is not cleared
module spi_nor_flash_command_sequencer_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [2:0]                    req_opcode,
   input  logic [snfc_pkg::ADDR_W-1:0]   req_address,
   input  logic [snfc_pkg::LEN_W-1:0]    req_length,
   input  logic [7:0]                    req_data_byte,
   input  logic [1:0]                    req_spi_status,
   output logic                          empty,
   input  logic                          pop,
   output logic [1:0]                    rsp_kind,
   output logic [7:0]                    rsp_byte_value,
   output logic                          rsp_frame_end,
   output logic [2:0]                    rsp_status,
   output logic                          rsp_last,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [snfc_pkg::LIMIT_W-1:0]  csr_wdata
);

   logic                           q_valid, q_pop;
   snfc_pkg::item_type             q_item;
   logic [snfc_pkg::OQ_CW-1:0]     oq_count;
   logic [1:0]                     wr_n;
   snfc_pkg::result_type           wr_r0, wr_r1, head;

   snfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .opcode     (req_opcode),
      .address    (req_address),
      .length     (req_length),
      .data_byte  (req_data_byte),
      .spi_status (req_spi_status),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   snfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_valid  (q_valid),
      .in_item   (q_item),
      .in_pop    (q_pop),
      .oq_count  (oq_count),
      .wr_n      (wr_n),
      .wr_r0     (wr_r0),
      .wr_r1     (wr_r1)
   );

   snfc_outq u_outq (
      .clock (clock),
      .reset (reset),
      .wr_n  (wr_n),
      .wr_r0 (wr_r0),
      .wr_r1 (wr_r1),
      .count (oq_count),
      .empty (empty),
      .pop   (pop),
      .head  (head)
   );

   assign rsp_kind       = head.kind;
   assign rsp_byte_value = head.byte_value;
   assign rsp_frame_end  = head.frame_end;
   assign rsp_status     = head.status;
   assign rsp_last       = head.last;

endmodule

// ===== test/spi_nor_flash_command_sequencer_top_tb.sv =====
module spi_nor_flash_command_sequencer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {
      FL_IDLE, FL_ID, FL_READ, FL_WE_ERASE, FL_ERASE, FL_WE_PROG, FL_PROG, FL_POLL_ERASE,
      FL_POLL_PROG
   } flash_phase_type;

   typedef struct packed {
      logic [2:0]                  opcode;
      logic [snfc_pkg::ADDR_W-1:0] address;
      logic [snfc_pkg::LEN_W-1:0]  length;
      logic [7:0]                  data_byte;
      logic [1:0]                  spi_status;
   } flash_req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] byte_value;
      logic       frame_end;
      logic [2:0] status;
      logic       last;
   } flash_rsp_type;

   typedef struct {
      flash_req_type req;
      bit            typed;
      flash_rsp_type rsp;
   } table_row_type;

   logic clock, reset, push, full, empty, pop;
   logic [2:0] req_opcode;
   logic [snfc_pkg::ADDR_W-1:0] req_address;
   logic [snfc_pkg::LEN_W-1:0] req_length;
   logic [7:0] req_data_byte;
   logic [1:0] req_spi_status;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_byte_value;
   logic rsp_frame_end;
   logic [2:0] rsp_status;
   logic rsp_last;
   logic csr_we, csr_index;
   logic [snfc_pkg::LIMIT_W-1:0] csr_wdata;

   spi_nor_flash_command_sequencer_top i_dut (.*);

   // predictor state
   flash_phase_type phase;
   int unsigned frame_pos, xfer_len, polls;
   logic [snfc_pkg::ADDR_W-1:0] target_addr;
   logic [15:0] erase_limit, prog_limit;
   logic [7:0] page_buf [256];
   flash_rsp_type expected_rsps [$];
   flash_rsp_type step_rsps [$];

   int errors = 0, n_rsps = 0, n_items = 0;
   bit rx_idle_ok = 1, rx_hold = 0, tx_idle_ok = 1;

   function automatic void emit(logic [1:0] k, logic [7:0] b, logic fe, logic [2:0] st);
      flash_rsp_type r;
      r = '{kind: k, byte_value: b, frame_end: fe, status: st, last: 1'b0};
      step_rsps.push_back(r);
   endfunction

   function automatic void finish_cmd(logic [2:0] st);
      emit(snfc_pkg::KIND_DONE, 8'h00, 1'b1, st);
      phase = FL_IDLE;
      frame_pos = 0;
   endfunction

   function automatic int unsigned frame_len();
      case (phase)
         FL_ID, FL_ERASE: return 4;
         FL_READ: return 5 + xfer_len;
         FL_PROG: return 4 + xfer_len;
         FL_POLL_ERASE, FL_POLL_PROG: return 2;
         default: return 1;
      endcase
   endfunction

   function automatic logic [7:0] addr_byte(int unsigned p);
      return target_addr[8*(3-p) +: 8];
   endfunction

   function automatic logic [7:0] tx_byte(int unsigned p);
      case (phase)
         FL_ID: return p == 0 ? snfc_pkg::FL_READ_ID : snfc_pkg::FL_DUMMY;
         FL_READ: begin
            if (p == 0) return snfc_pkg::FL_FAST_READ;
            if (p <= 3) return addr_byte(p);
            return p == 4 ? snfc_pkg::FL_DUMMY : snfc_pkg::FL_FILL;
         end
         FL_WE_ERASE, FL_WE_PROG: return snfc_pkg::FL_WREN;
         FL_ERASE: return p == 0 ? snfc_pkg::FL_SE : addr_byte(p);
         FL_PROG: begin
            if (p == 0) return snfc_pkg::FL_PP;
            if (p <= 3) return addr_byte(p);
            return page_buf[8'(target_addr + p - 4)];
         end
         FL_POLL_ERASE, FL_POLL_PROG: return p == 0 ? snfc_pkg::FL_RDSR1 : snfc_pkg::FL_DUMMY;
         default: return 8'h00;
      endcase
   endfunction

   function automatic void send_at(int unsigned p);
      frame_pos = p;
      emit(snfc_pkg::KIND_TX, tx_byte(p), (p + 1 == frame_len()), snfc_pkg::ST_OK);
   endfunction

   function automatic void start_poll(flash_phase_type ph, logic [15:0] lim);
      if (lim == 0) begin
         finish_cmd(snfc_pkg::ST_TIMEOUT);
         return;
      end
      phase = ph;
      polls = 0;
      send_at(0);
   endfunction

   function automatic void frame_done();
      case (phase)
         FL_WE_ERASE: begin phase = FL_ERASE; send_at(0); end
         FL_WE_PROG: begin phase = FL_PROG; send_at(0); end
         FL_ERASE: start_poll(FL_POLL_ERASE, erase_limit);
         FL_PROG: start_poll(FL_POLL_PROG, prog_limit);
         default: finish_cmd(snfc_pkg::ST_OK);
      endcase
   endfunction

   function automatic void predict_flash(flash_req_type r);
      int unsigned p;
      logic [15:0] lim;
      step_rsps.delete();
      if (r.opcode == snfc_pkg::OPC_LOAD) begin
         page_buf[r.address[7:0]] = r.data_byte;
      end else if (r.opcode <= snfc_pkg::OPC_PROG) begin
         if (phase == FL_IDLE) begin
            if (r.opcode == snfc_pkg::OPC_ID) begin
               phase = FL_ID; xfer_len = 0; send_at(0);
            end else if (r.opcode == snfc_pkg::OPC_READ) begin
               if (r.length == 0) finish_cmd(snfc_pkg::ST_ARG);
               else begin
                  phase = FL_READ; target_addr = r.address; xfer_len = r.length; send_at(0);
               end
            end else if (r.opcode == snfc_pkg::OPC_ERASE) begin
               phase = FL_WE_ERASE;
               target_addr = r.address - r.address % snfc_pkg::SECTOR_BYTES;
               send_at(0);
            end else begin
               if (r.address % snfc_pkg::PAGE_BYTES != 0 || r.length == 0 ||
                   r.length > snfc_pkg::PAGE_BYTES)
                  finish_cmd(snfc_pkg::ST_ALIGN);
               else begin
                  phase = FL_WE_PROG; target_addr = r.address; xfer_len = r.length; send_at(0);
               end
            end
         end
      end else if (r.opcode == snfc_pkg::OPC_SPI && phase != FL_IDLE) begin
         p = frame_pos;
         if (r.spi_status != snfc_pkg::SPI_OK)
            finish_cmd(r.spi_status == snfc_pkg::SPI_TIMEOUT ? snfc_pkg::ST_TIMEOUT
                                                              : snfc_pkg::ST_SPI_ERR);
         else begin
            if ((phase == FL_ID && p >= 1) || (phase == FL_READ && p >= 5))
               emit(snfc_pkg::KIND_DATA, r.data_byte, 1'b0, snfc_pkg::ST_OK);
            if ((phase == FL_POLL_ERASE || phase == FL_POLL_PROG) && p == 1) begin
               lim = phase == FL_POLL_ERASE ? erase_limit : prog_limit;
               if (!r.data_byte[0]) finish_cmd(snfc_pkg::ST_OK);
               else begin
                  polls++;
                  if (polls >= lim) finish_cmd(snfc_pkg::ST_TIMEOUT);
                  else send_at(0);
               end
            end else if (p + 1 < frame_len()) send_at(p + 1);
            else frame_done();
         end
      end
      if (step_rsps.size() > 0) step_rsps[$].last = 1'b1;
   endfunction

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // result side: random pops, optional long hold
   initial begin
      int gap;
      pop = 0;
      forever begin
         @(posedge clock);
         if (rx_hold) pop <= 0;
         else if (rx_idle_ok && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            pop <= 0;
            repeat (gap - 1) @(posedge clock);
         end else pop <= 1;
      end
   end

   always @(posedge clock) begin
      flash_rsp_type got, exp;
      if (!reset && pop && !empty) begin
         got = '{rsp_kind, rsp_byte_value, rsp_frame_end, rsp_status, rsp_last};
         n_rsps++;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %p", $time, got);
            errors++;
         end else begin
            exp = expected_rsps.pop_front();
            if (got.kind !== exp.kind) begin
               $display("%0t: kind expected %0d actual %0d", $time, exp.kind, got.kind);
               errors++;
            end
            if (got.byte_value !== exp.byte_value) begin
               $display("%0t: byte expected %h actual %h", $time, exp.byte_value,
                        got.byte_value);
               errors++;
            end
            if (got.frame_end !== exp.frame_end) begin
               $display("%0t: frame_end expected %0d actual %0d", $time, exp.frame_end,
                        got.frame_end);
               errors++;
            end
            if (got.status !== exp.status) begin
               $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
               errors++;
            end
            if (got.last !== exp.last) begin
               $display("%0t: last expected %0d actual %0d", $time, exp.last, got.last);
               errors++;
            end
         end
      end
   end

   // one transaction; the expected results come from the predictor, and a typed row is checked against it
   task automatic send_req(flash_req_type r, bit typed = 0, flash_rsp_type tr = '0);
      push <= 1;
      req_opcode <= r.opcode;
      req_address <= r.address;
      req_length <= r.length;
      req_data_byte <= r.data_byte;
      req_spi_status <= r.spi_status;
      do @(posedge clock); while (full);
      predict_flash(r);
      n_items++;
      if (typed && (step_rsps.size() != 1 || step_rsps[0] !== tr)) begin
         $display("%0t: table row expected %p actual predictor %p", $time, tr, step_rsps);
         errors++;
      end
      foreach (step_rsps[i]) expected_rsps.push_back(step_rsps[i]);
      if (tx_idle_ok && $urandom_range(0, 5) == 0) begin
         push <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic drain();
      push <= 0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(logic idx, logic [15:0] v);
      csr_we <= 1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      if (idx == snfc_pkg::CSR_ERASE_LIMIT) erase_limit = v; else prog_limit = v;
   endtask

   function automatic flash_req_type mk(logic [2:0] op, logic [23:0] a = 0,
                                        logic [15:0] l = 0, logic [7:0] d = 0,
                                        logic [1:0] s = 0);
      return '{op, a, l, d, s};
   endfunction

   // spi reply while a command runs: mostly ok, busy bit random
   function automatic flash_req_type spi_reply();
      logic [1:0] s;
      s = ($urandom_range(0, 60) == 0) ? 2'($urandom_range(1, 3)) : snfc_pkg::SPI_OK;
      return mk(snfc_pkg::OPC_SPI, 24'($urandom), 16'($urandom), 8'($urandom), s);
   endfunction

   task automatic run_command();
      flash_req_type r;
      int unsigned sel, guard;
      logic [23:0] a;
      sel = $urandom_range(0, 9);
      a = 24'($urandom);
      if (sel < 2) r = mk(snfc_pkg::OPC_ID);
      else if (sel < 4) r = mk(snfc_pkg::OPC_READ, a,
                               ($urandom_range(0, 20) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(0, 6)));
      else if (sel < 6) r = mk(snfc_pkg::OPC_ERASE, a);
      else if (sel < 9) r = mk(snfc_pkg::OPC_PROG,
                               $urandom_range(0, 7) == 0 ? a : {a[23:8], 8'h00},
                               $urandom_range(0, 7) == 0 ? 16'($urandom_range(0, 300))
                                                         : 16'($urandom_range(1, 8)));
      else r = mk(3'($urandom_range(0, 7)), a, 16'($urandom), 8'($urandom),
                  2'($urandom));
      // keep long reads short
      if (r.opcode == snfc_pkg::OPC_READ && r.length > 40) r.length = 16'($urandom_range(7, 40));
      send_req(r);
      guard = 0;
      while (phase != FL_IDLE && guard < 60) begin
         if ($urandom_range(0, 15) == 0)
            r = mk(snfc_pkg::OPC_LOAD, 24'($urandom), 0, 8'($urandom));
         else if ($urandom_range(0, 30) == 0) r = mk(3'($urandom_range(1, 4)), 24'($urandom),
                                                     16'($urandom));
         else r = spi_reply();
         if ((phase == FL_POLL_ERASE || phase == FL_POLL_PROG) &&
             r.opcode == snfc_pkg::OPC_SPI)
            r.data_byte[0] = $urandom_range(0, 2) != 0;
         send_req(r);
         guard++;
      end
      while (phase != FL_IDLE) begin
         r = spi_reply();
         r.data_byte[0] = 0;
         send_req(r);
      end
   endtask

   table_row_type rows [$];

   initial begin
      flash_rsp_type none;
      none = '0;
      push = 0; req_opcode = 0; req_address = 0; req_length = 0; req_data_byte = 0;
      req_spi_status = 0; csr_we = 0; csr_index = 0; csr_wdata = 0;
      phase = FL_IDLE; frame_pos = 0; xfer_len = 0; polls = 0; target_addr = 0;
      erase_limit = snfc_pkg::ERASE_LIMIT_RST; prog_limit = snfc_pkg::PROG_LIMIT_RST;
      reset = 1;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // fill the whole page buffer so no program reads an unwritten byte
      for (int i = 0; i < 256; i++) send_req(mk(snfc_pkg::OPC_LOAD, 24'(i), 0, 8'($urandom)));
      send_req(mk(snfc_pkg::OPC_LOAD, 24'hFFFFFF, 16'hFFFF, 8'hFF, 2'b11));
      send_req(mk(snfc_pkg::OPC_LOAD, 24'h000000, 0, 8'h00));

      rows.push_back('{mk(snfc_pkg::OPC_SPI, 0, 0, 8'hAA), 0, none});
      rows.push_back('{mk(snfc_pkg::OPC_READ, 24'hFFFFFF, 16'h0000), 1,
                       '{snfc_pkg::KIND_DONE, 8'h00, 1'b1, snfc_pkg::ST_ARG, 1'b1}});
      rows.push_back('{mk(snfc_pkg::OPC_PROG, 24'h000001, 16'd4), 1,
                       '{snfc_pkg::KIND_DONE, 8'h00, 1'b1, snfc_pkg::ST_ALIGN, 1'b1}});
      rows.push_back('{mk(snfc_pkg::OPC_PROG, 24'h000100, 16'd0), 1,
                       '{snfc_pkg::KIND_DONE, 8'h00, 1'b1, snfc_pkg::ST_ALIGN, 1'b1}});
      rows.push_back('{mk(snfc_pkg::OPC_PROG, 24'hFFFF00, 16'hFFFF), 1,
                       '{snfc_pkg::KIND_DONE, 8'h00, 1'b1, snfc_pkg::ST_ALIGN, 1'b1}});
      rows.push_back('{mk(3'd6, 24'hFFFFFF, 16'hFFFF, 8'hFF, 2'b11), 0, none});
      rows.push_back('{mk(3'd7), 0, none});
      rows.push_back('{mk(snfc_pkg::OPC_ID), 1,
                       '{snfc_pkg::KIND_TX, snfc_pkg::FL_READ_ID, 1'b0, snfc_pkg::ST_OK, 1'b1}});
      rows.push_back('{mk(snfc_pkg::OPC_ERASE, 24'h123456), 0, none});
      rows.push_back('{mk(snfc_pkg::OPC_SPI, 0, 0, 8'hEF), 0, none});
      rows.push_back('{mk(snfc_pkg::OPC_SPI, 0, 0, 8'h40), 0, none});
      rows.push_back('{mk(snfc_pkg::OPC_SPI, 0, 0, 8'h00, 2'd1), 1,
                       '{snfc_pkg::KIND_DONE, 8'h00, 1'b1, snfc_pkg::ST_TIMEOUT, 1'b1}});
      rows.push_back('{mk(snfc_pkg::OPC_READ, 24'hABCDEF, 16'd1), 1,
                       '{snfc_pkg::KIND_TX, snfc_pkg::FL_FAST_READ, 1'b0, snfc_pkg::ST_OK,
                         1'b1}});
      rows.push_back('{mk(snfc_pkg::OPC_SPI, 0, 0, 8'h00, 2'd3), 1,
                       '{snfc_pkg::KIND_DONE, 8'h00, 1'b1, snfc_pkg::ST_SPI_ERR, 1'b1}});
      rows.push_back('{mk(snfc_pkg::OPC_ERASE, 24'hFFFFFF), 1,
                       '{snfc_pkg::KIND_TX, snfc_pkg::FL_WREN, 1'b1, snfc_pkg::ST_OK, 1'b1}});
      rows.push_back('{mk(snfc_pkg::OPC_SPI, 0, 0, 8'h00, 2'd2), 1,
                       '{snfc_pkg::KIND_DONE, 8'h00, 1'b1, snfc_pkg::ST_SPI_ERR, 1'b1}});
      foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].rsp);
      drain();

      // full commands at reset limits, then the extremes of both limits
      for (int k = 0; k < 6; k++) run_command();
      drain();
      write_limit(snfc_pkg::CSR_ERASE_LIMIT, 16'd0);
      write_limit(snfc_pkg::CSR_PROG_LIMIT, 16'd0);
      for (int k = 0; k < 8; k++) run_command();
      drain();
      write_limit(snfc_pkg::CSR_ERASE_LIMIT, 16'd1);
      write_limit(snfc_pkg::CSR_PROG_LIMIT, 16'hFFFF);
      for (int k = 0; k < 8; k++) run_command();

      // receiver stalls long while the sender keeps pushing
      rx_hold = 1;
      fork
         begin repeat (60) @(posedge clock); rx_hold = 0; end
         for (int k = 0; k < 4; k++) run_command();
      join
      drain();
      write_limit(snfc_pkg::CSR_ERASE_LIMIT, 16'hFFFF);
      write_limit(snfc_pkg::CSR_PROG_LIMIT, 16'd1);
      while (n_items < 1000) run_command();
      drain();
      write_limit(snfc_pkg::CSR_ERASE_LIMIT, 16'd3);
      write_limit(snfc_pkg::CSR_PROG_LIMIT, 16'd2);
      rx_idle_ok = 0;
      tx_idle_ok = 0;
      while (n_items < 1400) run_command();
      push <= 0;
      fork
         begin
            while (expected_rsps.size() != 0) @(posedge clock);
            repeat (10) @(posedge clock);
         end
         begin repeat (200000) @(posedge clock); end
      join_any
      if (expected_rsps.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, expected_rsps.size());
         errors++;
      end
      $display("covered %0d transactions, %0d responses: id, read, erase, program,", n_items,
               n_rsps);
      $display("poll limits at both ends, spi errors, ignored requests and a full stall");
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// ===== spi_nor_flash_command_sequencer_top.f =====
sv/snfc_pkg.sv
sv/snfc_front.sv
sv/snfc_back.sv
sv/snfc_outq.sv
sv/spi_nor_flash_command_sequencer_top.sv
test/spi_nor_flash_command_sequencer_top_tb.sv
